FILE: rtl/core/s1h_pkg.sv
package s1h_pkg;

  // Input action codes
  localparam logic [1:0] ACT_ABSORB = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_PAD    = 2'd2;

  // Source of the byte pushed into the block window
  localparam logic [1:0] SRC_IN   = 2'd0;
  localparam logic [1:0] SRC_MARK = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  localparam int          BLOCK_WORDS = 16;
  localparam int          DIGEST_WORDS = 5;
  localparam int          ROUNDS = 80;
  localparam int          COUNT_W = 61;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  localparam logic [31:0] K_ROUND [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       push;       // shift one byte into the block window
    logic [1:0] byte_sel;   // SRC_* code
    logic       count_inc;  // message byte: bump the length count
    logic       init;       // load working vars, clear round counter
    logic       round;      // run one compression round
    logic       add;        // fold working vars into the chaining value
    logic       emit;       // load next digest word into output register
    logic       restart;    // back to the initial hash state
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pos_last;    // next byte completes the block
    logic pos_hi;      // next byte lands in the length field
    logic round_last;  // final round of the compression
    logic out_free;    // output register can take a word
    logic emit_last;   // next digest word is the final one
  } dp_stat_t;

endpackage

FILE: rtl/core/s1h_if.sv
interface s1h_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface s1h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

FILE: rtl/core/s1h_ctrl.sv
module s1h_ctrl
  import s1h_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_ready,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MARK  = 3'd1;
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] ret, ret_next;     // where to go after a compression
  logic       spill, spill_next; // current padding block is not the final one
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      spill <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      spill <= spill_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    ret_next   = ret;
    spill_next = spill;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_ABSORB: begin
              cmd.push      = 1'b1;
              cmd.byte_sel  = SRC_IN;
              cmd.count_inc = 1'b1;
              if (stat.pos_last) begin
                cmd.init   = 1'b1;
                ret_next   = ST_IDLE;
                state_next = ST_ROUND;
              end
            end
            ACT_FINISH: begin
              cmd.push      = 1'b1;
              cmd.byte_sel  = SRC_IN;
              cmd.count_inc = 1'b1;
              if (stat.pos_last) begin
                cmd.init   = 1'b1;
                ret_next   = ST_MARK;
                state_next = ST_ROUND;
              end else begin
                state_next = ST_MARK;
              end
            end
            ACT_PAD: state_next = ST_MARK;
            default: ;  // unused code: dropped
          endcase
        end
      end
      ST_MARK: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = SRC_MARK;
        if (stat.pos_last) begin
          // marker filled the block; length goes in a fresh one
          cmd.init   = 1'b1;
          spill_next = 1'b0;
          ret_next   = ST_FILL;
          state_next = ST_ROUND;
        end else begin
          spill_next = stat.pos_hi;
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = (stat.pos_hi && !spill) ? SRC_LEN : SRC_ZERO;
        if (stat.pos_last) begin
          cmd.init   = 1'b1;
          ret_next   = spill ? ST_FILL : ST_OUT;
          spill_next = 1'b0;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (stat.round_last) state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ret;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            cmd.restart = 1'b1;
            state_next  = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/s1h_datapath.sv
module s1h_datapath
  import s1h_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  // Block window: 64-byte shift line while filling, W schedule during rounds.
  logic [31:0]        win [BLOCK_WORDS];
  logic [31:0]        chain [DIGEST_WORDS];
  logic [31:0]        a, b, c, d, e;
  logic [6:0]         round;
  logic [5:0]         pos;
  logic [COUNT_W-1:0] count;
  logic [2:0]         out_idx;

  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [7:0]  push_byte;
  logic [31:0] f, k, sum, w_new;

  assign bit_len  = {count, 3'b000};
  assign len_byte = bit_len[{~pos[2:0], 3'b000} +: 8];

  always_comb begin
    unique case (cmd.byte_sel)
      SRC_IN:   push_byte = data_byte;
      SRC_MARK: push_byte = PAD_MARK;
      SRC_ZERO: push_byte = 8'h00;
      SRC_LEN:  push_byte = len_byte;
      default:  push_byte = 8'h00;
    endcase
  end

  always_comb begin
    if (round < 7'd20) begin
      f = d ^ (b & (c ^ d));
      k = K_ROUND[0];
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K_ROUND[1];
    end else if (round < 7'd60) begin
      f = (b & c) | (d & (b | c));
      k = K_ROUND[2];
    end else begin
      f = b ^ c ^ d;
      k = K_ROUND[3];
    end
  end

  assign sum   = {a[26:0], a[31:27]} + f + e + win[0] + k;
  assign w_new = win[13] ^ win[8] ^ win[2] ^ win[0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++)
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      win[BLOCK_WORDS-1] <= {win[BLOCK_WORDS-1][23:0], push_byte};
    end else if (cmd.round) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++)
        win[i] <= win[i+1];
      win[BLOCK_WORDS-1] <= {w_new[30:0], w_new[31]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (cmd.round) begin
      a <= sum;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round   <= '0;
      pos     <= '0;
      count   <= '0;
      out_idx <= '0;
      for (int i = 0; i < DIGEST_WORDS; i++) chain[i] <= H_INIT[i];
    end else begin
      if (cmd.init)
        round <= '0;
      else if (cmd.round)
        round <= round + 7'd1;
      if (cmd.push) pos <= pos + 6'd1;
      if (cmd.count_inc) count <= count + COUNT_W'(1);
      if (cmd.add) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
      if (cmd.emit && !cmd.restart) out_idx <= out_idx + 3'd1;
      if (cmd.restart) begin
        pos     <= '0;
        count   <= '0;
        out_idx <= '0;
        for (int i = 0; i < DIGEST_WORDS; i++) chain[i] <= H_INIT[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digest_word <= chain[out_idx];
      word_index  <= out_idx;
      last_word   <= (out_idx == 3'(DIGEST_WORDS - 1));
    end
  end

  assign stat.pos_last   = (pos == 6'd63);
  assign stat.pos_hi     = (pos >= 6'd56);
  assign stat.round_last = (round == 7'(ROUNDS - 1));
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.emit_last  = (out_idx == 3'(DIGEST_WORDS - 1));

endmodule

FILE: rtl/core/sha1_byte_stream_hasher.sv
// SHA-1 hasher fed one message byte per transaction. Action ABSORB (0) adds a
// byte, FINISH (1) adds a byte and closes the message, PAD (2) closes the
// message with no byte; code 3 is accepted and dropped. On close the block
// appends the standard padding (0x80, zeros, 64-bit big-endian bit length,
// spilling into a second block when needed) and returns the digest as five
// output transactions, H0 first, word_index 0..4, last_word on the fifth;
// it then starts over for the next message. The bit length wraps modulo 2^64.
// Each full 64-byte block is followed by its compression (80 rounds on one
// shared round unit, one per cycle, plus the chaining add), during which
// in_ch.ready is low. Closing a message feeds the padding through the same
// one-byte-per-cycle block window, runs one or two compressions, then loads
// the five digest words into the output register one at a time, waiting
// whenever out_ch stalls. Input is taken again as soon as the last word sits
// in the output register.
module sha1_byte_stream_hasher
  import s1h_pkg::*;
(
  input logic clk,
  input logic rst,
  s1h_in_if.sink    in_ch,
  s1h_out_if.source out_ch
);

  dp_cmd_t  cmd;   // controller -> datapath
  dp_stat_t stat;  // datapath -> controller

  // Sequencer: byte intake, padding, round count, digest readout.
  s1h_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Block window / schedule, round unit, chaining value, output register.
  s1h_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (in_ch.data_byte),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .digest_word (out_ch.digest_word),
    .word_index  (out_ch.word_index),
    .last_word   (out_ch.last_word)
  );

endmodule

FILE: rtl/core/s1h_checker.sv
module s1h_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  logic [2:0] exp_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (out_valid && out_ready) begin
      exp_idx <= last_word ? 3'd0 : exp_idx + 3'd1;
    end
  end

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word)
      && $stable(word_index) && $stable(last_word))
    else $error("output payload changed while stalled");

  // Digest words come out in order, five per message
  a_out_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> word_index == exp_idx)
    else $error("digest word out of order");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_word == (word_index == 3'd4))
    else $error("last_word does not match word_index");

  // No new input while the digest is still being read out
  a_no_intake: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_index != 3'd4 |-> !in_ready)
    else $error("input taken during digest readout");

endmodule

bind sha1_byte_stream_hasher s1h_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .digest_word (out_ch.digest_word),
  .word_index  (out_ch.word_index),
  .last_word   (out_ch.last_word)
);
